### design/pts_pkg.sv
// periodic task slot scheduler: shared types, command and status codes
// no dependencies; imported by every design file of the block
package pts_pkg;

  localparam int ID_BITS = 8;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 3;
  localparam int STAT_W  = 2;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BEGIN  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_STOP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REPORT = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE_DUE  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [TIME_W-1:0]  period;
    logic [ID_BITS-1:0] task_id;
    logic               keep;
  } req_t;

  typedef struct packed {
    logic [ID_BITS-1:0] result_id;
    logic [STAT_W-1:0]  status;
    logic               last;
  } rsp_t;

  // which result the output register takes
  typedef enum logic [2:0] {
    SEL_ZERO_OK,
    SEL_FULL,
    SEL_NEW_ID,
    SEL_ECHO_OK,
    SEL_NOT_FOUND,
    SEL_PEND_MID,
    SEL_PEND_LAST,
    SEL_NONE_DUE
  } rsp_sel_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_FREE_SEARCH,
    S_ID_SEARCH,
    S_FIND,
    S_SCAN_WALK,
    S_RESPOND
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic     clr_write;
    logic     load_item;
    logic     do_tick;
    logic     freeze;
    logic     idx_clear;
    logic     idx_advance;
    logic     id_start;
    logic     id_next;
    logic     id_claim;
    logic     slot_free;
    logic     slot_rearm;
    logic     pend_clear;
    logic     pend_push;
    logic     out_load;
    rsp_sel_t sel;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             keep;
    logic             clr_end;
    logic             slot_valid;
    logic             at_end;
    logic             cand_used;
    logic             tid_known;
    logic             slot_match;
    logic             slot_due;
    logic             pend_valid;
    logic             out_free;
  } dp_status_t;

  // next id candidate, never zero
  function automatic logic [ID_BITS-1:0] id_step(input logic [ID_BITS-1:0] x);
    logic [ID_BITS-1:0] n;
    n = x + 1'b1;
    if (n == '0) begin
      n = {{(ID_BITS-1){1'b0}}, 1'b1};
    end
    return n;
  endfunction

endpackage

### design/periodic_task_slot_scheduler.sv
// periodic task slot scheduler: top level joining controller and datapath
// depends on pts_pkg, pts_ctrl and pts_dpath
//
// A table of SLOTS task slots (id, period, last run time) with a tick counter stepped
// by tick. Each request beat carries one command; tick, begin, stop and report give one
// response beat, scan gives one beat per due task in slot order with last set on the
// final one, or a single "no task due" beat. The block takes one command at a time:
// req_stall is low only while the controller is idle, and a finished response may still
// sit in the output register, waiting on rsp_stall, when the next command is taken.
// Command-to-command spacing is set by the walk over the slot table, one slot per clock
// through the single read port of the slot memories while a scan is not held by a due
// result waiting on a stalled response: tick, unused codes and a stop or report of an id
// not in use walk no slots; stop and report of a live id walk up to its slot; begin walks
// to the first free slot and then steps past ids that are in use, or walks every slot on
// a full table; scan walks every slot. Every command also waits for the output register
// to take its final beat.
// Slot valid bits are flip-flops cleared by reset. The id-in-use bitmap is a memory
// with a registered read port; after reset a clearing pass zeroes it one id per clock,
// so req_stall stays high until all 2^ID_BITS (256) ids are cleared.
module periodic_task_slot_scheduler import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic clk,
  input  logic rst,
  // request channel
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  // response channel
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  ctrl_cmd_t  ctl;
  dp_status_t sts;

  // sequencing of every command
  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .sts       (sts),
    .req_stall (req_stall),
    .ctl       (ctl)
  );

  // slot table, time keeping, id issue and response register
  pts_dpath #(
    .SLOTS (SLOTS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

### design/pts_dpath.sv
// periodic task slot scheduler: datapath with slot memories, valid bits, id-in-use bitmap,
// tick and frozen time, id issue, scan compare and output register; uses pts_pkg
module pts_dpath import pts_pkg::*; #(
  parameter int SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  req_t       req,
  input  ctrl_cmd_t  ctl,
  input  logic       rsp_stall,
  output dp_status_t sts,
  output logic       rsp_valid,
  output rsp_t       rsp
);

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int IDS    = 1 << ID_BITS;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

  req_t               item;
  logic [TIME_W-1:0]  tick_count;
  logic [TIME_W-1:0]  frozen_time;
  logic [TIME_W-1:0]  tick_inc;
  logic [TIME_W-1:0]  elapsed;
  logic [ID_BITS-1:0] last_issued;
  logic [ID_BITS-1:0] cand;
  logic [ID_BITS-1:0] pend_id;
  logic               pend_valid;
  logic [SLOTS-1:0]   valid;
  logic [SLOT_W-1:0]  idx;
  logic [SLOT_W-1:0]  idx_inc;
  logic [SLOT_W-1:0]  rd_addr;
  logic [ID_BITS-1:0] clr_addr;
  logic [ID_BITS-1:0] used_addr;
  logic               used_q;

  logic [ID_BITS-1:0] mem_id     [SLOTS];
  logic [TIME_W-1:0]  mem_period [SLOTS];
  logic [TIME_W-1:0]  mem_last   [SLOTS];
  logic               id_used    [IDS];
  logic [ID_BITS-1:0] r_id;
  logic [TIME_W-1:0]  r_period;
  logic [TIME_W-1:0]  r_last;

  always_comb begin
    idx_inc  = (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    rd_addr  = ctl.idx_clear ? '0 : (ctl.idx_advance ? idx_inc : idx);
    tick_inc = tick_count + 1'b1;
    elapsed  = frozen_time - r_last;
  end

  // bitmap read address follows the id that the next cycle looks at
  always_comb begin
    priority if (ctl.load_item) begin
      used_addr = req.task_id;
    end else if (ctl.id_start) begin
      used_addr = id_step(last_issued);
    end else if (ctl.id_next) begin
      used_addr = id_step(cand);
    end else begin
      used_addr = cand;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      frozen_time <= '0;
      last_issued <= '0;
      valid       <= '0;
      clr_addr    <= '0;
      pend_valid  <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (ctl.clr_write) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (ctl.do_tick) begin
        tick_count <= (tick_inc == TIME_MAX) ? '0 : tick_inc;
      end
      if (ctl.freeze) begin
        frozen_time <= tick_count;
      end
      if (ctl.id_claim) begin
        valid[idx]  <= 1'b1;
        last_issued <= cand;
      end
      if (ctl.slot_free) begin
        valid[idx] <= 1'b0;
      end
      if (ctl.pend_clear) begin
        pend_valid <= 1'b0;
      end else if (ctl.pend_push) begin
        pend_valid <= 1'b1;
      end
      if (ctl.out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      item <= req;
    end
    if (ctl.idx_clear) begin
      idx <= '0;
    end else if (ctl.idx_advance) begin
      idx <= idx_inc;
    end
    if (ctl.id_start) begin
      cand <= id_step(last_issued);
    end else if (ctl.id_next) begin
      cand <= id_step(cand);
    end
    if (ctl.pend_push) begin
      pend_id <= r_id;
    end
    if (ctl.out_load) begin
      unique case (ctl.sel)
        SEL_ZERO_OK:   rsp <= '{result_id: '0,           status: ST_OK,        last: 1'b1};
        SEL_FULL:      rsp <= '{result_id: '0,           status: ST_FULL,      last: 1'b1};
        SEL_NEW_ID:    rsp <= '{result_id: last_issued,  status: ST_OK,        last: 1'b1};
        SEL_ECHO_OK:   rsp <= '{result_id: item.task_id, status: ST_OK,        last: 1'b1};
        SEL_NOT_FOUND: rsp <= '{result_id: item.task_id, status: ST_NOT_FOUND, last: 1'b1};
        SEL_PEND_MID:  rsp <= '{result_id: pend_id,      status: ST_OK,        last: 1'b0};
        SEL_PEND_LAST: rsp <= '{result_id: pend_id,      status: ST_OK,        last: 1'b1};
        SEL_NONE_DUE:  rsp <= '{result_id: '0,           status: ST_NONE_DUE,  last: 1'b1};
      endcase
    end
  end

  // slot memories, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (ctl.id_claim) begin
      mem_id[idx]     <= cand;
      mem_period[idx] <= item.period;
    end
    if (ctl.id_claim || ctl.slot_rearm) begin
      mem_last[idx] <= frozen_time;
    end
    r_id     <= mem_id[rd_addr];
    r_period <= mem_period[rd_addr];
    r_last   <= mem_last[rd_addr];
  end

  // id-in-use bitmap, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctl.clr_write) begin
      id_used[clr_addr] <= 1'b0;
    end else if (ctl.id_claim) begin
      id_used[cand] <= 1'b1;
    end else if (ctl.slot_free) begin
      id_used[item.task_id] <= 1'b0;
    end
    used_q <= id_used[used_addr];
  end

  always_comb begin
    sts.cmd        = item.cmd;
    sts.keep       = item.keep;
    sts.clr_end    = (clr_addr == '1);
    sts.slot_valid = valid[idx];
    sts.at_end     = (idx == LAST_SLOT);
    sts.cand_used  = used_q;
    sts.tid_known  = (item.task_id != '0) && used_q;
    sts.slot_match = valid[idx] && (r_id == item.task_id);
    sts.slot_due   = valid[idx] && (elapsed >= r_period);
    sts.pend_valid = pend_valid;
    sts.out_free   = !rsp_valid || !rsp_stall;
  end

endmodule

### design/pts_ctrl.sv
// periodic task slot scheduler: controller state machine sequencing each command
// over the slot walk; uses pts_pkg, drives pts_dpath through ctrl_cmd_t
module pts_ctrl import pts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  dp_status_t sts,
  output logic       req_stall,
  output ctrl_cmd_t  ctl
);

  state_t   state, state_next;
  rsp_sel_t sel, sel_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      sel   <= SEL_ZERO_OK;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  always_comb begin
    state_next = state;
    sel_next   = sel;
    ctl        = '0;
    ctl.sel    = sel;
    req_stall  = (state != S_IDLE);

    unique case (state)
      // id-in-use bitmap cleared one id per clock after reset
      S_CLEAR: begin
        ctl.clr_write = 1'b1;
        if (sts.clr_end) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_valid) begin
          ctl.load_item = 1'b1;
          state_next    = S_DECODE;
        end
      end

      S_DECODE: begin
        unique case (sts.cmd)
          CMD_TICK: begin
            ctl.do_tick = 1'b1;
            sel_next    = SEL_ZERO_OK;
            state_next  = S_RESPOND;
          end
          CMD_BEGIN: begin
            ctl.idx_clear = 1'b1;
            ctl.id_start  = 1'b1;
            state_next    = S_FREE_SEARCH;
          end
          CMD_STOP, CMD_REPORT: begin
            if (sts.tid_known) begin
              ctl.idx_clear = 1'b1;
              state_next    = S_FIND;
            end else begin
              sel_next   = SEL_NOT_FOUND;
              state_next = S_RESPOND;
            end
          end
          CMD_SCAN: begin
            ctl.freeze     = 1'b1;
            ctl.idx_clear  = 1'b1;
            ctl.pend_clear = 1'b1;
            state_next     = S_SCAN_WALK;
          end
          default: begin
            sel_next   = SEL_ZERO_OK;
            state_next = S_RESPOND;
          end
        endcase
      end

      S_FREE_SEARCH: begin
        priority if (!sts.slot_valid) begin
          state_next = S_ID_SEARCH;
        end else if (sts.at_end) begin
          sel_next   = SEL_FULL;
          state_next = S_RESPOND;
        end else begin
          ctl.idx_advance = 1'b1;
        end
      end

      // a free slot exists, so fewer ids are in use than there are nonzero ids
      S_ID_SEARCH: begin
        if (sts.cand_used) begin
          ctl.id_next = 1'b1;
        end else begin
          ctl.id_claim = 1'b1;
          sel_next     = SEL_NEW_ID;
          state_next   = S_RESPOND;
        end
      end

      S_FIND: begin
        priority if (sts.slot_match) begin
          if (sts.cmd == CMD_REPORT && sts.keep) begin
            ctl.slot_rearm = 1'b1;
          end else begin
            ctl.slot_free = 1'b1;
          end
          sel_next   = SEL_ECHO_OK;
          state_next = S_RESPOND;
        end else if (sts.at_end) begin
          sel_next   = SEL_NOT_FOUND;
          state_next = S_RESPOND;
        end else begin
          ctl.idx_advance = 1'b1;
        end
      end

      // one due result is held back so the final one can carry last
      S_SCAN_WALK: begin
        if (!(sts.slot_due && sts.pend_valid && !sts.out_free)) begin
          if (sts.slot_due) begin
            ctl.pend_push = 1'b1;
            if (sts.pend_valid) begin
              ctl.out_load = 1'b1;
              ctl.sel      = SEL_PEND_MID;
            end
          end
          if (sts.at_end) begin
            sel_next   = (sts.slot_due || sts.pend_valid) ? SEL_PEND_LAST : SEL_NONE_DUE;
            state_next = S_RESPOND;
          end else begin
            ctl.idx_advance = 1'b1;
          end
        end
      end

      S_RESPOND: begin
        if (sts.out_free) begin
          ctl.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/pts_chk.sv
// periodic task slot scheduler: port-level checker and its bind to the top level
// depends on pts_pkg and periodic_task_slot_scheduler
module pts_chk import pts_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input req_t req,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled response beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response beat changed while stalled");

  // every error or empty outcome ends its command
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.last)
    else $error("non-ok response without last");

  a_zero_id: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL || rsp.status == ST_NONE_DUE)
      |-> rsp.result_id == '0)
    else $error("full or none-due response with nonzero id");

  // only a scan gives more than one beat, and those name live tasks
  a_mid_beat: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.last |-> rsp.status == ST_OK && rsp.result_id != '0)
    else $error("intermediate scan beat malformed");

  // one command at a time
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second command taken back to back");

endmodule

bind periodic_task_slot_scheduler pts_chk u_pts_chk (.*);
